### design/shape_coverage_sampler_unit_defines.svh
// assertion macros used by the checker file
`ifndef SHAPE_COVERAGE_SAMPLER_UNIT_DEFINES_SVH
`define SHAPE_COVERAGE_SAMPLER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SCS_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("scs check failed");

// next-cycle implication, disabled while reset is low
`define SCS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scs check failed");

`endif

### design/scs_pkg.sv
`default_nettype none

package scs_pkg;

  // table sizes
  localparam int CIRCLE_SLOTS   = 4;
  localparam int TRIANGLE_SLOTS = 4;
  localparam int MAX_SLOTS      = (CIRCLE_SLOTS > TRIANGLE_SLOTS) ? CIRCLE_SLOTS
                                                                  : TRIANGLE_SLOTS;
  localparam int CIDX_W = (CIRCLE_SLOTS > 1) ? $clog2(CIRCLE_SLOTS) : 1;
  localparam int TIDX_W = (TRIANGLE_SLOTS > 1) ? $clog2(TRIANGLE_SLOTS) : 1;
  localparam int OP_W   = $clog2(MAX_SLOTS + 1);

  // field and datapath widths
  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 2;
  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int CNT_W     = 32;
  localparam int USED_W    = 3;
  localparam int LANES     = 6;
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 72;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRCLES_USED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLES_USED = 2'd1;

  // item kinds carried on tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_CIRCLE = 2'd0,
    CMD_LOAD_TRI    = 2'd1,
    CMD_TEST        = 2'd2,
    CMD_CLEAR       = 2'd3
  } cmd_e;

  // controller to datapath commands
  typedef struct packed {
    logic            load_circle;
    logic            load_tri;
    logic            clear_cnt;
    logic            start;
    logic            issue;
    logic            issue_circle;
    logic [OP_W-1:0] op_slot;
    logic            finish;
  } scs_cmd_t;

endpackage

`default_nettype wire

### design/scs_ctrl.sv
`default_nettype none

module scs_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [scs_pkg::CMD_W-1:0]     s_axis_tuser,
  input  wire logic                          cfg_we_i,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [scs_pkg::USED_W-1:0]    cfg_data_i,
  input  wire logic                          out_free_i,
  output scs_pkg::scs_cmd_t                  cmd_o
);
  import scs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CIRC  = 3'd1;
  localparam logic [2:0] ST_TRI   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d, op_inc;
  logic              drn_q, drn_d;
  logic [USED_W-1:0] circ_used_q, tri_used_q;
  logic [OP_W-1:0]   nc, nt;
  logic              accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_used_q <= '0;
      tri_used_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CIRCLES_USED) circ_used_q <= cfg_data_i;
      if (cfg_idx_i == CFG_TRIANGLES_USED) tri_used_q <= cfg_data_i;
    end
  end

  // active slot counts, clipped to the table sizes
  assign nc = (int'(circ_used_q) < CIRCLE_SLOTS) ? OP_W'(circ_used_q) : OP_W'(CIRCLE_SLOTS);
  assign nt = (int'(tri_used_q) < TRIANGLE_SLOTS) ? OP_W'(tri_used_q)
                                                  : OP_W'(TRIANGLE_SLOTS);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op_inc        = op_q + OP_W'(1);

  // sequencer: one shape per cycle, circles first, then triangles
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    drn_d   = drn_q;
    cmd_o   = '0;
    cmd_o.op_slot = op_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            CMD_LOAD_CIRCLE: cmd_o.load_circle = 1'b1;
            CMD_LOAD_TRI:    cmd_o.load_tri = 1'b1;
            CMD_CLEAR:       cmd_o.clear_cnt = 1'b1;
            CMD_TEST: begin
              cmd_o.start = 1'b1;
              op_d  = '0;
              drn_d = 1'b0;
              if (nc != '0) state_d = ST_CIRC;
              else if (nt != '0) state_d = ST_TRI;
              else state_d = ST_DRAIN;
            end
            default: ;
          endcase
        end
      end
      ST_CIRC: begin
        cmd_o.issue        = 1'b1;
        cmd_o.issue_circle = 1'b1;
        if (op_inc == nc) begin
          op_d    = '0;
          state_d = (nt != '0) ? ST_TRI : ST_DRAIN;
        end else begin
          op_d = op_inc;
        end
      end
      ST_TRI: begin
        cmd_o.issue = 1'b1;
        if (op_inc == nt) begin
          op_d    = '0;
          state_d = ST_DRAIN;
        end else begin
          op_d = op_inc;
        end
      end
      ST_DRAIN: begin
        // wait for the last shape to leave the product and compare stages
        drn_d = 1'b1;
        if (drn_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      drn_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      drn_q   <= drn_d;
    end
  end

endmodule

`default_nettype wire

### design/scs_datapath.sv
`default_nettype none

module scs_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire scs_pkg::scs_cmd_t             cmd_i,
  input  wire logic [scs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                               out_free_o,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [scs_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
  import scs_pkg::*;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  // input fields
  logic        [SLOT_W-1:0]  slot;
  logic signed [COORD_W-1:0] xa, ya, xb, yb, xc, yc;
  assign slot = s_axis_tdata[1:0];
  assign xa   = s_axis_tdata[17:2];
  assign ya   = s_axis_tdata[33:18];
  assign xb   = s_axis_tdata[49:34];
  assign yb   = s_axis_tdata[65:50];
  assign xc   = s_axis_tdata[81:66];
  assign yc   = s_axis_tdata[97:82];

  // shape tables
  logic signed [COORD_W-1:0] cir_x_q [CIRCLE_SLOTS];
  logic signed [COORD_W-1:0] cir_y_q [CIRCLE_SLOTS];
  logic signed [COORD_W-1:0] cir_r_q [CIRCLE_SLOTS];
  logic signed [COORD_W-1:0] ax_q [TRIANGLE_SLOTS];
  logic signed [COORD_W-1:0] ay_q [TRIANGLE_SLOTS];
  logic signed [COORD_W-1:0] bx_q [TRIANGLE_SLOTS];
  logic signed [COORD_W-1:0] by_q [TRIANGLE_SLOTS];
  logic signed [COORD_W-1:0] cx_q [TRIANGLE_SLOTS];
  logic signed [COORD_W-1:0] cy_q [TRIANGLE_SLOTS];
  logic [CIDX_W-1:0] c_wr, c_rd;
  logic [TIDX_W-1:0] t_wr, t_rd;

  assign c_wr = CIDX_W'(slot);
  assign t_wr = TIDX_W'(slot);
  assign c_rd = CIDX_W'(cmd_i.op_slot);
  assign t_rd = TIDX_W'(cmd_i.op_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CIRCLE_SLOTS; i++) begin
        cir_x_q[i] <= '0;
        cir_y_q[i] <= '0;
        cir_r_q[i] <= '0;
      end
      for (int i = 0; i < TRIANGLE_SLOTS; i++) begin
        ax_q[i] <= '0;
        ay_q[i] <= '0;
        bx_q[i] <= '0;
        by_q[i] <= '0;
        cx_q[i] <= '0;
        cy_q[i] <= '0;
      end
    end else begin
      // loads to slots past the table end are dropped
      if (cmd_i.load_circle && (int'(slot) < CIRCLE_SLOTS)) begin
        cir_x_q[c_wr] <= xa;
        cir_y_q[c_wr] <= ya;
        cir_r_q[c_wr] <= xb;
      end
      if (cmd_i.load_tri && (int'(slot) < TRIANGLE_SLOTS)) begin
        ax_q[t_wr] <= xa;
        ay_q[t_wr] <= ya;
        bx_q[t_wr] <= xb;
        by_q[t_wr] <= yb;
        cx_q[t_wr] <= xc;
        cy_q[t_wr] <= yc;
      end
    end
  end

  // sample point, held for the whole test
  logic signed [COORD_W-1:0] px_q, py_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= xa;
      py_q <= ya;
    end
  end

  // stage 1: operand differences for six multiplier lanes
  logic signed [DIFF_W-1:0] u_d [LANES];
  logic signed [DIFF_W-1:0] v_d [LANES];
  logic signed [DIFF_W-1:0] u_q [LANES];
  logic signed [DIFF_W-1:0] v_q [LANES];
  logic                     s1_vld_q, s1_circ_q;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      u_d[j] = '0;
      v_d[j] = '0;
    end
    if (cmd_i.issue_circle) begin
      // dx*dx, dy*dy, r*r
      u_d[0] = sdiff(px_q, cir_x_q[c_rd]);
      v_d[0] = u_d[0];
      u_d[1] = sdiff(py_q, cir_y_q[c_rd]);
      v_d[1] = u_d[1];
      u_d[2] = $signed({cir_r_q[c_rd][COORD_W-1], cir_r_q[c_rd]});
      v_d[2] = u_d[2];
    end else begin
      // edge a-b, edge b-c, edge c-a cross products
      u_d[0] = sdiff(px_q, ax_q[t_rd]);
      v_d[0] = sdiff(by_q[t_rd], ay_q[t_rd]);
      u_d[1] = sdiff(py_q, ay_q[t_rd]);
      v_d[1] = sdiff(bx_q[t_rd], ax_q[t_rd]);
      u_d[2] = sdiff(px_q, bx_q[t_rd]);
      v_d[2] = sdiff(cy_q[t_rd], by_q[t_rd]);
      u_d[3] = sdiff(py_q, by_q[t_rd]);
      v_d[3] = sdiff(cx_q[t_rd], bx_q[t_rd]);
      u_d[4] = sdiff(px_q, cx_q[t_rd]);
      v_d[4] = sdiff(ay_q[t_rd], cy_q[t_rd]);
      u_d[5] = sdiff(py_q, cy_q[t_rd]);
      v_d[5] = sdiff(ax_q[t_rd], cx_q[t_rd]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < LANES; j++) begin
      u_q[j] <= u_d[j];
      v_q[j] <= v_d[j];
    end
  end

  // stage 2: products
  logic signed [PROD_W-1:0] prod_q [LANES];
  logic                     s2_vld_q, s2_circ_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < LANES; j++) begin
      prod_q[j] <= PROD_W'(u_q[j]) * PROD_W'(v_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_circ_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_circ_q <= 1'b0;
    end else begin
      s1_vld_q  <= cmd_i.issue;
      s1_circ_q <= cmd_i.issue_circle;
      s2_vld_q  <= s1_vld_q;
      s2_circ_q <= s1_circ_q;
    end
  end

  // stage 3: radius compare or edge sign test
  logic signed [SUM_W-1:0] circ_sum, e0, e1, e2;
  logic                    circ_hit, tri_neg, tri_pos, shape_hit;

  assign circ_sum  = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]);
  assign circ_hit  = (circ_sum <= SUM_W'(prod_q[2]));
  assign e0        = SUM_W'(prod_q[0]) - SUM_W'(prod_q[1]);
  assign e1        = SUM_W'(prod_q[2]) - SUM_W'(prod_q[3]);
  assign e2        = SUM_W'(prod_q[4]) - SUM_W'(prod_q[5]);
  assign tri_neg   = e0[SUM_W-1] || e1[SUM_W-1] || e2[SUM_W-1];
  assign tri_pos   = (!e0[SUM_W-1] && (e0 != '0)) || (!e1[SUM_W-1] && (e1 != '0))
                  || (!e2[SUM_W-1] && (e2 != '0));
  assign shape_hit = s2_circ_q ? circ_hit : !(tri_neg && tri_pos);

  logic hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q <= 1'b0;
    end else if (s2_vld_q && shape_hit) begin
      hit_q <= 1'b1;
    end
  end

  // saturating counts
  logic [CNT_W-1:0] miss_q, samp_q, miss_d, samp_d;

  assign samp_d = (samp_q == '1) ? samp_q : samp_q + CNT_W'(1);
  assign miss_d = (hit_q || (miss_q == '1)) ? miss_q : miss_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= '0;
      samp_q <= '0;
    end else if (cmd_i.clear_cnt) begin
      miss_q <= '0;
      samp_q <= '0;
    end else if (cmd_i.finish) begin
      miss_q <= miss_d;
      samp_q <= samp_d;
    end
  end

  // output register
  logic                 m_vld_q;
  logic [M_TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      m_data_q <= {(M_TDATA_W - 2 * CNT_W - 1)'(0), samp_d, miss_d, hit_q};
    end
  end

  assign out_free_o    = !m_vld_q || m_axis_tready;
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

### design/shape_coverage_sampler_unit.sv
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: cmd; tdata: slot, x_a, y_a, x_b, y_b, x_c, y_c
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: covered, uncovered_count, sample_count
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// load and clear items complete on acceptance and leave the input ready.
// a test item runs in order: accept, the active shapes (used counts clipped to four
// slots each) through the six-lane multiplier datapath, a drain of the product and
// compare stages, then posting the result.
// reset clears the shape tables, counts and configuration at once; no clearing pass.
// a waiting result stalls only a following test item before it posts; loads and clears go on.
`default_nettype none

module shape_coverage_sampler_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tuser: cmd[1:0]
  input  wire logic [scs_pkg::CMD_W-1:0]     s_axis_tuser,
  // tdata: slot[1:0], x_a[17:2], y_a[33:18], x_b[49:34], y_b[65:50], x_c[81:66],
  // y_c[97:82], zero fill[103:98]
  input  wire logic [scs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: covered[0], uncovered_count[32:1], sample_count[64:33], zero fill[71:65]
  output logic [scs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [scs_pkg::USED_W-1:0]    cfg_data_i
);
  import scs_pkg::*;

  scs_cmd_t cmd;
  logic     out_free;

  // sequencer
  scs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_free_i    (out_free),
    .cmd_o         (cmd)
  );

  // tables, shape test pipeline, counts and output register
  scs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .s_axis_tdata  (s_axis_tdata),
    .out_free_o    (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### design/scs_checker.sv
`default_nettype none
`include "shape_coverage_sampler_unit_defines.svh"

module scs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [scs_pkg::CMD_W-1:0]     s_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [scs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import scs_pkg::*;

  // a stalled result holds
  `SCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // misses never outnumber samples
  `SCS_ASSERT_NOW(a_cnt_order, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[32:1] <= m_axis_tdata[64:33])

  // a test item keeps the input closed in the next cycle
  `SCS_ASSERT_NEXT(a_test_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TEST), !s_axis_tready)

  // loads and clears leave the input open in the next cycle
  `SCS_ASSERT_NEXT(a_load_quick, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_TEST), s_axis_tready)

endmodule

bind shape_coverage_sampler_unit scs_checker u_scs_checker (.*);

`default_nettype wire
